>>> sv/scta_pkg.sv
`timescale 1ns / 1ps
package scta_pkg;

  localparam int LINE_CAPACITY = 256;
  localparam int APPEND_LIMIT  = (LINE_CAPACITY - 1 > 255) ? 255 : LINE_CAPACITY - 1;
  localparam int CODE_TOP      = 57;
  localparam int MAP_DEPTH     = CODE_TOP + 1;

  localparam logic [7:0] SC_RELEASE = 8'h80;
  localparam logic [7:0] SC_KEY     = 8'h7F;
  localparam logic [7:0] SC_LSHIFT  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT  = 8'h36;
  localparam logic [7:0] SC_CTRL    = 8'h1D;
  localparam logic [7:0] SC_ALT     = 8'h38;
  localparam logic [7:0] SC_CAPS    = 8'h3A;
  localparam logic [7:0] SC_UP      = 8'h48;
  localparam logic [7:0] SC_DOWN    = 8'h50;
  localparam logic [7:0] SC_BKSP    = 8'h0E;
  localparam logic [7:0] SC_ENTER   = 8'h1C;

  localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
  localparam logic [6:0] CHAR_LOWER_C = 7'h63;

  typedef enum logic [3:0] {
    EV_NONE  = 4'd0,
    EV_CHAR  = 4'd1,
    EV_BKSP  = 4'd2,
    EV_ENTER = 4'd3,
    EV_INTR  = 4'd4,
    EV_HUP   = 4'd5,
    EV_HDOWN = 4'd6,
    EV_SUP   = 4'd7,
    EV_SDOWN = 4'd8
  } event_e;

  typedef struct packed {
    logic shift;
    logic caps;
    logic ctrl;
    logic alt;
  } mod_state_t;

  typedef struct packed {
    event_e     event_res;
    logic [6:0] char_code;
    logic [7:0] line_length;
    mod_state_t mods;
  } result_t;

  localparam logic [6:0] LOWER_MAP [MAP_DEPTH] = '{
    7'h3F, 7'h3F, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h3F, 7'h3F, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h3F, 7'h3F,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h3F, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h3F, 7'h3F, 7'h3F, 7'h20
  };

  localparam logic [6:0] UPPER_MAP [MAP_DEPTH] = '{
    7'h3F, 7'h3F, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h3F, 7'h3F, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h3F, 7'h3F,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h3F, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h3F, 7'h3F, 7'h3F, 7'h20
  };

  function automatic logic [6:0] lookup_char(input logic [5:0] idx, input logic upper);
    logic [6:0] ch;
    if (idx > 6'(CODE_TOP)) begin
      ch = CHAR_UNKNOWN;
    end else if (upper) begin
      ch = UPPER_MAP[idx];
    end else begin
      ch = LOWER_MAP[idx];
    end
    return ch;
  endfunction

endpackage

>>> sv/scta_if.sv
`timescale 1ns / 1ps
interface scta_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_code;

  modport source (output valid, output scan_code, input ready);
  modport sink   (input valid, input scan_code, output ready);
endinterface

interface scta_res_if;
  logic                valid;
  logic                ready;
  scta_pkg::event_e    event_res;
  logic [6:0]          char_code;
  logic [7:0]          line_length;
  logic                shift_state;
  logic                caps_state;
  logic                ctrl_state;
  logic                alt_state;

  modport source (
    output valid, output event_res, output char_code, output line_length,
    output shift_state, output caps_state, output ctrl_state, output alt_state,
    input ready
  );
  modport sink (
    input valid, input event_res, input char_code, input line_length,
    input shift_state, input caps_state, input ctrl_state, input alt_state,
    output ready
  );
endinterface

>>> sv/scta_decode.sv
`timescale 1ns / 1ps
module scta_decode (
  input  logic [7:0]           scan_code_i,
  input  scta_pkg::mod_state_t mods_i,
  input  logic [7:0]           count_i,
  output scta_pkg::result_t    res_o
);
  import scta_pkg::*;

  logic [7:0] key;
  logic [6:0] letter;

  assign key    = scan_code_i & SC_KEY;
  assign letter = lookup_char(scan_code_i[5:0], mods_i.shift ^ mods_i.caps);

  always_comb begin
    res_o.event_res   = EV_NONE;
    res_o.char_code   = '0;
    res_o.line_length = count_i;
    res_o.mods        = mods_i;
    if ((scan_code_i & SC_RELEASE) != '0) begin
      if (key inside {SC_LSHIFT, SC_RSHIFT}) begin
        res_o.mods.shift = 1'b0;
      end else if (key == SC_CTRL) begin
        res_o.mods.ctrl = 1'b0;
      end else if (key == SC_ALT) begin
        res_o.mods.alt = 1'b0;
      end
    end else if (scan_code_i inside {SC_LSHIFT, SC_RSHIFT}) begin
      res_o.mods.shift = 1'b1;
    end else if (scan_code_i == SC_CTRL) begin
      res_o.mods.ctrl = 1'b1;
    end else if (scan_code_i == SC_ALT) begin
      res_o.mods.alt = 1'b1;
    end else if (scan_code_i == SC_CAPS) begin
      res_o.mods.caps = ~mods_i.caps;
    end else if (scan_code_i == SC_UP) begin
      res_o.event_res = mods_i.shift ? EV_SUP : EV_HUP;
    end else if (scan_code_i == SC_DOWN) begin
      res_o.event_res = mods_i.shift ? EV_SDOWN : EV_HDOWN;
    end else if (scan_code_i <= 8'(CODE_TOP)) begin
      if (mods_i.ctrl && letter == CHAR_LOWER_C) begin
        res_o.event_res   = EV_INTR;
        res_o.line_length = '0;
      end else if (scan_code_i == SC_BKSP) begin
        if (count_i != '0) begin
          res_o.event_res   = EV_BKSP;
          res_o.line_length = count_i - 8'd1;
        end
      end else if (scan_code_i == SC_ENTER) begin
        res_o.event_res   = EV_ENTER;
        res_o.line_length = '0;
      end else if (count_i < 8'(APPEND_LIMIT)) begin
        res_o.event_res   = EV_CHAR;
        res_o.char_code   = letter;
        res_o.line_length = count_i + 8'd1;
      end
    end
  end

endmodule

>>> sv/scan_code_to_ascii_line_editor.sv
`timescale 1ns / 1ps
// Channel   Dir  Modport  Payload
// scan_i    in   sink     scan_code[7:0]
// res_o     out  source   event_res, char_code, line_length, shift/caps/ctrl/alt state
//
// One scan code per cycle while scan_i.ready is high; each result is registered.
// The decode and table lookup sit between the key state and the result register.
// A skid register behind the result register keeps scan_i.ready registered,
// so a stalled result costs no input cycle until both stages are full.
// Reset clears key state, line count and both valid flags.
module scan_code_to_ascii_line_editor (
  input logic          clk_i,
  input logic          rst_ni,
  scta_scan_if.sink    scan_i,
  scta_res_if.source   res_o
);
  import scta_pkg::*;

  mod_state_t mods_q;
  logic [7:0] count_q;
  result_t    res_d;
  result_t    out_q;
  result_t    skid_q;
  logic       out_v_q;
  logic       skid_v_q;
  logic       in_fire;
  logic       out_free;

  scta_decode u_decode (
    .scan_code_i (scan_i.scan_code),
    .mods_i      (mods_q),
    .count_i     (count_q),
    .res_o       (res_d)
  );

  assign scan_i.ready = ~skid_v_q;
  assign in_fire      = scan_i.valid & ~skid_v_q;
  assign out_free     = ~out_v_q | res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q   <= '0;
      count_q  <= '0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mods_q  <= res_d.mods;
        count_q <= res_d.line_length;
      end
      if (out_free) begin
        out_v_q  <= skid_v_q | in_fire;
        skid_v_q <= 1'b0;
      end else if (in_fire) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (in_fire) begin
      skid_q <= res_d;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.event_res   = out_q.event_res;
  assign res_o.char_code   = out_q.char_code;
  assign res_o.line_length = out_q.line_length;
  assign res_o.shift_state = out_q.mods.shift;
  assign res_o.caps_state  = out_q.mods.caps;
  assign res_o.ctrl_state  = out_q.mods.ctrl;
  assign res_o.alt_state   = out_q.mods.alt;

endmodule

>>> sv/scta_checker.sv
`timescale 1ns / 1ps
module scta_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] event_i,
  input logic [6:0] char_i,
  input logic [7:0] length_i
);
  import scta_pkg::*;

  logic       prev_v_q;
  logic [7:0] prev_len_q;
  logic       out_fire;

  assign out_fire = out_valid_i & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_v_q   <= 1'b0;
      prev_len_q <= '0;
    end else if (out_fire) begin
      prev_v_q   <= 1'b1;
      prev_len_q <= length_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(event_i) && $stable(char_i) && $stable(length_i))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> out_valid_i)
    else $error("accepted scan code produced no result");

  a_char_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_v_q && event_i == EV_CHAR |-> length_i == prev_len_q + 8'd1)
    else $error("character did not grow the line by one");

  a_bksp_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_v_q && event_i == EV_BKSP |-> length_i == prev_len_q - 8'd1)
    else $error("backspace did not shrink the line by one");

endmodule

bind scan_code_to_ascii_line_editor scta_checker u_scta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (scan_i.valid),
  .in_ready_i  (scan_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .event_i     (res_o.event_res),
  .char_i      (res_o.char_code),
  .length_i    (res_o.line_length)
);

>>> tb/sv/scan_code_to_ascii_line_editor_tb.sv
`timescale 1ns / 1ps
module scan_code_to_ascii_line_editor_tb;
  import scta_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int FILL_ITEMS  = 260;

  localparam logic [7:0] SC_KEY_NUL = 8'h00;
  localparam logic [7:0] SC_KEY_1   = 8'h02;
  localparam logic [7:0] SC_KEY_Q   = 8'h10;
  localparam logic [7:0] SC_KEY_P   = 8'h19;
  localparam logic [7:0] SC_KEY_A   = 8'h1E;
  localparam logic [7:0] SC_KEY_C   = 8'h2E;
  localparam logic [7:0] SC_SPACE   = 8'h39;
  localparam logic [7:0] SC_TOP     = 8'h7F;
  localparam logic [7:0] SC_ALL_SET = 8'hFF;

  localparam int SCRIPT_LEN = 26;
  localparam logic [7:0] KEY_SCRIPT [SCRIPT_LEN] = '{
    SC_KEY_A, SC_KEY_NUL, SC_SPACE, SC_CAPS, SC_KEY_A, SC_CAPS, SC_LSHIFT, SC_KEY_1,
    SC_UP, SC_DOWN, SC_RELEASE | SC_LSHIFT, SC_UP, SC_DOWN, SC_CTRL, SC_RSHIFT,
    SC_KEY_C, SC_RELEASE | SC_RSHIFT, SC_KEY_C, SC_RELEASE | SC_CTRL, SC_BKSP,
    SC_ALT, SC_RELEASE | SC_ALT, SC_ENTER, SC_ALL_SET, SC_TOP, SC_KEY_A
  };

  class key_line_tracker;
    result_t     pending_results[$];
    int unsigned mismatches;
    logic        shift_held;
    logic        caps_on;
    logic        ctrl_held;
    logic        alt_held;
    logic [7:0]  line_count;
    string       lower_glyphs;
    string       upper_glyphs;

    function new();
      mismatches   = 0;
      shift_held   = 1'b0;
      caps_on      = 1'b0;
      ctrl_held    = 1'b0;
      alt_held     = 1'b0;
      line_count   = '0;
      lower_glyphs = "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./??? ";
      upper_glyphs = "??!@#$%^&*()_+??QWERTYUIOP{}??ASDFGHJKL:\"~?|ZXCVBNM<>???? ";
    endfunction

    function logic [6:0] glyph(logic [5:0] idx, logic upper);
      byte b;
      b = upper ? upper_glyphs[idx] : lower_glyphs[idx];
      return b[6:0];
    endfunction

    function void note_scan(logic [7:0] code);
      result_t    r;
      logic [6:0] ch;
      logic [6:0] key;
      r.event_res = EV_NONE;
      r.char_code = '0;
      key = code[6:0];
      if (code[7]) begin
        if (key == SC_LSHIFT[6:0] || key == SC_RSHIFT[6:0]) begin
          shift_held = 1'b0;
        end else if (key == SC_CTRL[6:0]) begin
          ctrl_held = 1'b0;
        end else if (key == SC_ALT[6:0]) begin
          alt_held = 1'b0;
        end
      end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        shift_held = 1'b1;
      end else if (code == SC_CTRL) begin
        ctrl_held = 1'b1;
      end else if (code == SC_ALT) begin
        alt_held = 1'b1;
      end else if (code == SC_CAPS) begin
        caps_on = ~caps_on;
      end else if (code == SC_UP) begin
        r.event_res = shift_held ? EV_SUP : EV_HUP;
      end else if (code == SC_DOWN) begin
        r.event_res = shift_held ? EV_SDOWN : EV_HDOWN;
      end else if (code <= CODE_TOP) begin
        ch = glyph(code[5:0], shift_held ^ caps_on);
        if (ctrl_held && ch == CHAR_LOWER_C) begin
          r.event_res = EV_INTR;
          line_count  = '0;
        end else if (code == SC_BKSP) begin
          if (line_count != 0) begin
            line_count  = line_count - 8'd1;
            r.event_res = EV_BKSP;
          end
        end else if (code == SC_ENTER) begin
          line_count  = '0;
          r.event_res = EV_ENTER;
        end else if (line_count < APPEND_LIMIT) begin
          line_count  = line_count + 8'd1;
          r.event_res = EV_CHAR;
          r.char_code = ch;
        end
      end
      r.line_length = line_count;
      r.mods.shift  = shift_held;
      r.mods.caps   = caps_on;
      r.mods.ctrl   = ctrl_held;
      r.mods.alt    = alt_held;
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      bad;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result with no scan code pending: ev=%0d ch=%02h len=%0d mods=%b",
                   $realtime, got.event_res, got.char_code, got.line_length, got.mods);
        end
        return;
      end
      want = pending_results.pop_front();
      bad = (got.event_res !== want.event_res) || (got.char_code !== want.char_code) ||
            (got.line_length !== want.line_length) || (got.mods.shift !== want.mods.shift) ||
            (got.mods.caps !== want.mods.caps) || (got.mods.ctrl !== want.mods.ctrl) ||
            (got.mods.alt !== want.mods.alt);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: exp ev=%0d ch=%02h len=%0d mods=%b / got ev=%0d ch=%02h len=%0d mods=%b",
                   $realtime, want.event_res, want.char_code, want.line_length, want.mods,
                   got.event_res, got.char_code, got.line_length, got.mods);
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on;
  bit   hold_request;
  int   cycle_count;

  key_line_tracker tracker;

  scta_scan_if scan_if ();
  scta_res_if  res_if ();

  scan_code_to_ascii_line_editor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .scan_i (scan_if),
    .res_o  (res_if)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_scan(input logic [7:0] code);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      scan_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    scan_if.valid     = 1'b1;
    scan_if.scan_code = code;
    do @(posedge clk_i); while (!scan_if.ready);
    tracker.note_scan(code);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_scan();
    int unsigned sel;
    logic [7:0]  code;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      code = 8'($urandom_range(0, CODE_TOP));
    end else if (sel < 58) begin
      code = SC_BKSP;
    end else if (sel < 61) begin
      code = SC_ENTER;
    end else if (sel < 73) begin
      case ($urandom_range(0, 3))
        0: code = SC_RELEASE | SC_LSHIFT;
        1: code = SC_RELEASE | SC_RSHIFT;
        2: code = SC_RELEASE | SC_CTRL;
        default: code = SC_RELEASE | SC_ALT;
      endcase
    end else if (sel < 80) begin
      case ($urandom_range(0, 4))
        0: code = SC_LSHIFT;
        1: code = SC_RSHIFT;
        2: code = SC_CTRL;
        3: code = SC_ALT;
        default: code = SC_CAPS;
      endcase
    end else if (sel < 86) begin
      code = $urandom_range(0, 1) ? SC_UP : SC_DOWN;
    end else if (sel < 88) begin
      code = SC_KEY_C;
    end else begin
      code = 8'($urandom_range(0, 255));
    end
    return code;
  endfunction

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int stall_left;
      @(negedge clk_i);
      if (hold_request) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        res_if.ready = 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        res_if.ready = 1'b0;
        stall_left   = $urandom_range(0, 9);
      end else begin
        res_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : capture
    result_t seen;
    if (rst_ni && res_if.valid && res_if.ready) begin
      seen.event_res   = res_if.event_res;
      seen.char_code   = res_if.char_code;
      seen.line_length = res_if.line_length;
      seen.mods.shift  = res_if.shift_state;
      seen.mods.caps   = res_if.caps_state;
      seen.mods.ctrl   = res_if.ctrl_state;
      seen.mods.alt    = res_if.alt_state;
      tracker.check_result(seen);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("scan_code_to_ascii_line_editor_tb NOT OK");
    $finish;
  end

  initial begin
    tracker           = new();
    scan_if.valid     = 1'b0;
    scan_if.scan_code = '0;
    idle_on           = 1'b1;
    hold_request      = 1'b0;
    rst_ni            = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_scan(KEY_SCRIPT[i]);
    end

    for (int i = 0; i < 110; i++) begin
      send_scan(pick_scan());
    end

    // fill the line past its limit with no idling, while the result side holds off at first
    idle_on      = 1'b0;
    hold_request = 1'b1;
    send_scan(SC_RELEASE | SC_CTRL);
    for (int i = 0; i < FILL_ITEMS; i++) begin
      send_scan(8'($urandom_range(SC_KEY_Q, SC_KEY_P)));
    end
    repeat (3) send_scan(SC_BKSP);

    idle_on = 1'b1;
    for (int i = 0; i < 80; i++) begin
      send_scan(pick_scan());
    end

    idle_on = 1'b0;
    for (int i = 0; i < 80; i++) begin
      send_scan(pick_scan());
    end
    scan_if.valid = 1'b0;

    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("scan_code_to_ascii_line_editor_tb OK");
    end else begin
      $display("scan_code_to_ascii_line_editor_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/scta_pkg.sv
sv/scta_if.sv
sv/scta_decode.sv
sv/scan_code_to_ascii_line_editor.sv
sv/scta_checker.sv
tb/sv/scan_code_to_ascii_line_editor_tb.sv
